// File: rtl/jst_pkg.sv
`default_nettype none
package jst_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int STACK_W   = MAX_DEPTH + 1;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 2);
    localparam int MAX_RES   = 6;
    localparam int RES_W     = $clog2(MAX_RES + 1);

    typedef enum logic [3:0] {
        PH_TOP, PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_KEY, PH_COLON, PH_AFTER,
        PH_STRING, PH_ESC, PH_HEX, PH_PEND, PH_PEND_BS, PH_PEND_HEX, PH_NUMBER,
        PH_LITERAL
    } phase_t;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
    localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
    localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
    localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
    localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
    localparam logic [3:0] EV_KEY_END   = 4'd6;
    localparam logic [3:0] EV_STR_BYTE  = 4'd7;
    localparam logic [3:0] EV_STR_END   = 4'd8;
    localparam logic [3:0] EV_NUM_BYTE  = 4'd9;
    localparam logic [3:0] EV_NUM_END   = 4'd10;
    localparam logic [3:0] EV_TRUE      = 4'd11;
    localparam logic [3:0] EV_FALSE     = 4'd12;
    localparam logic [3:0] EV_NULL      = 4'd13;
    localparam logic [3:0] EV_DOC_OK    = 4'd14;
    localparam logic [3:0] EV_ERROR     = 4'd15;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] d;
    } hex_t;

    // code point to utf-8 bytes, first byte in b[0]
    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t r;
        r.b = '0;
        if (cp <= 21'h7f) begin
            r.len = 3'd1;
            r.b[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            r.len = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            r.len = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end else begin
            r.len = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t r;
        r.ok = 1'b1;
        r.d  = 4'd0;
        if (c >= "0" && c <= "9") begin
            r.d = 4'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            r.d = 4'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            r.d = 4'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
    endfunction

    // literal spelling: kind 0 true, 1 false, 2 null
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (kind)
            2'd0: begin
                case (pos)
                    3'd0: r = "t";
                    3'd1: r = "r";
                    3'd2: r = "u";
                    3'd3: r = "e";
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: r = "f";
                    3'd1: r = "a";
                    3'd2: r = "l";
                    3'd3: r = "s";
                    3'd4: r = "e";
                    default: r = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: r = "n";
                    3'd1: r = "u";
                    3'd2: r = "l";
                    3'd3: r = "l";
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/json_stream_tokenizer.sv
// Streaming JSON tokenizer and grammar checker. One request is a document
// byte (action 0) or an end-of-document mark (action 1). Each request is
// decoded in the cycle it is taken and its results, up to six, are loaded
// into a small result queue that drains one result per cycle on the m_ side
// while m_ready is high; the last result of a request carries m_last_of_item.
// A request is taken while the queue is empty or as its last result is taken,
// so a byte waits until the results of the byte before it have drained (a \u
// escape that completes a code point gives up to six bytes). The object or
// array kind of each open level is held in a 65-entry shift register. After the
// first fault one error result is sent and further bytes give nothing until
// the end mark, which always gives a verdict and returns the block to reset.
`default_nettype none
module json_stream_tokenizer
    import jst_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_text_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_event_res,
    output logic [7:0]      m_data_byte,
    output logic            m_last_of_item
);

    // parser state
    phase_t             ph_reg, ph_next;
    logic [STACK_W-1:0] stk_reg, stk_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               key_reg, key_next;
    logic [15:0]        acc_reg, acc_next;
    logic [1:0]         hcnt_reg, hcnt_next;
    logic [15:0]        pend_reg, pend_next;
    logic               pendv_reg, pendv_next;
    logic [4:0]         lit_reg, lit_next;
    logic [2:0]         nph_reg, nph_next;
    logic               fail_reg, fail_next;

    // result queue
    logic [3:0]         qev_reg [MAX_RES];
    logic [7:0]         qdb_reg [MAX_RES];
    logic [RES_W-1:0]   qn_reg, qi_reg;

    // decode outputs
    logic [3:0]         rev [MAX_RES];
    logic [7:0]         rdb [MAX_RES];
    logic [RES_W-1:0]   rn;

    logic        take;
    logic [7:0]  c;
    logic        ws;
    hex_t        hv;
    logic        flt, numend, flush, utf_go, sgl;
    logic [20:0] utf_cp;
    logic [3:0]  sgl_ev;
    logic [7:0]  sgl_db;
    logic        fh_go, str_go, esc_go, sv_go, af_go;
    logic [15:0] fh_cp;
    logic [3:0]  sev;
    utf8_t       enc_p, enc_u;
    logic [1:0]  lkind;
    logic [2:0]  lpos;
    logic [2:0]  llen;

    assign take = s_valid && s_ready;
    assign c    = s_text_byte;
    assign ws   = is_ws(c);
    assign hv   = hex_val(c);
    assign sev  = key_reg ? EV_KEY_BYTE : EV_STR_BYTE;
    assign lkind = lit_reg[4:3];
    assign lpos  = lit_reg[2:0];
    assign llen  = (lkind == 2'd1) ? 3'd5 : 3'd4;

    // next state and result flags for one request
    always_comb begin
        ph_next = ph_reg;   stk_next = stk_reg;   cnt_next = cnt_reg;
        key_next = key_reg; acc_next = acc_reg;   hcnt_next = hcnt_reg;
        pend_next = pend_reg; pendv_next = pendv_reg; lit_next = lit_reg;
        nph_next = nph_reg; fail_next = fail_reg;
        flt = 1'b0; numend = 1'b0; flush = 1'b0; utf_go = 1'b0; utf_cp = '0;
        sgl = 1'b0; sgl_ev = EV_NONE; sgl_db = 8'h00;
        fh_go = 1'b0; fh_cp = '0; str_go = 1'b0; esc_go = 1'b0; sv_go = 1'b0;
        af_go = 1'b0;
        if (s_action) begin
            // end mark: verdict, then back to reset
            if (fail_reg) begin
                flt = 1'b1;
            end else if (cnt_reg == '0 && ph_reg == PH_NUMBER &&
                         (nph_reg == 3'd1 || nph_reg == 3'd3 || nph_reg == 3'd6)) begin
                numend = 1'b1; sgl = 1'b1; sgl_ev = EV_DOC_OK;
            end else if (cnt_reg == '0 && ph_reg == PH_AFTER) begin
                sgl = 1'b1; sgl_ev = EV_DOC_OK;
            end else begin
                flt = 1'b1;
            end
            ph_next = PH_TOP; stk_next = '0; cnt_next = '0; key_next = 1'b0;
            acc_next = '0; hcnt_next = '0; pend_next = '0; pendv_next = 1'b0;
            lit_next = '0; nph_next = '0; fail_next = 1'b0;
        end else if (!fail_reg) begin
            case (ph_reg)
                PH_TOP, PH_VALUE: begin
                    if (!ws) sv_go = 1'b1;
                end
                PH_ARR_FIRST: begin
                    if (!ws) begin
                        if (c == "]") begin
                            cnt_next = cnt_reg - 1'b1;
                            stk_next = stk_reg >> 1;
                            sgl = 1'b1; sgl_ev = EV_ARR_CLOSE;
                            ph_next = PH_AFTER;
                        end else begin
                            sv_go = 1'b1;
                        end
                    end
                end
                PH_OBJ_FIRST, PH_KEY: begin
                    if (!ws) begin
                        if (c == "}" && ph_reg == PH_OBJ_FIRST) begin
                            cnt_next = cnt_reg - 1'b1;
                            stk_next = stk_reg >> 1;
                            sgl = 1'b1; sgl_ev = EV_OBJ_CLOSE;
                            ph_next = PH_AFTER;
                        end else if (c == "\"") begin
                            key_next = 1'b1;
                            ph_next = PH_STRING;
                        end else begin
                            flt = 1'b1;
                        end
                    end
                end
                PH_COLON: begin
                    if (!ws) begin
                        if (c == ":") ph_next = PH_VALUE;
                        else flt = 1'b1;
                    end
                end
                PH_AFTER:  af_go = 1'b1;
                PH_STRING: str_go = 1'b1;
                PH_ESC:    esc_go = 1'b1;
                PH_HEX, PH_PEND_HEX: begin
                    if (!hv.ok) begin
                        flt = 1'b1;
                    end else begin
                        acc_next  = {acc_reg[11:0], hv.d};
                        hcnt_next = hcnt_reg + 1'b1;
                        if (hcnt_reg == 2'd3) begin
                            if (ph_reg == PH_HEX) begin
                                fh_go = 1'b1; fh_cp = acc_next;
                            end else if (acc_next >= 16'hdc00 && acc_next <= 16'hdfff) begin
                                // surrogate pair joined into one code point
                                utf_go = 1'b1;
                                utf_cp = 21'h10000 + {1'b0, pend_reg[9:0], acc_next[9:0]};
                                pend_next = '0; pendv_next = 1'b0;
                                ph_next = PH_STRING;
                            end else begin
                                flush = 1'b1;
                                pend_next = '0; pendv_next = 1'b0;
                                fh_go = 1'b1; fh_cp = acc_next;
                            end
                        end
                    end
                end
                PH_PEND: begin
                    if (c == "\\") begin
                        ph_next = PH_PEND_BS;
                    end else begin
                        flush = 1'b1; pend_next = '0; pendv_next = 1'b0;
                        ph_next = PH_STRING;
                        str_go = 1'b1;
                    end
                end
                PH_PEND_BS: begin
                    if (c == "u") begin
                        acc_next = '0; hcnt_next = '0;
                        ph_next = PH_PEND_HEX;
                    end else begin
                        flush = 1'b1; pend_next = '0; pendv_next = 1'b0;
                        esc_go = 1'b1;
                    end
                end
                PH_NUMBER: begin
                    if (c >= "0" && c <= "9") begin
                        if (nph_reg == 3'd0) nph_next = 3'd1;
                        else if (nph_reg == 3'd2) nph_next = 3'd3;
                        else if (nph_reg == 3'd4 || nph_reg == 3'd5) nph_next = 3'd6;
                        sgl = 1'b1; sgl_ev = EV_NUM_BYTE; sgl_db = c;
                    end else if (c == "." && nph_reg == 3'd1) begin
                        nph_next = 3'd2; sgl = 1'b1; sgl_ev = EV_NUM_BYTE; sgl_db = c;
                    end else if ((c == "e" || c == "E") &&
                                 (nph_reg == 3'd1 || nph_reg == 3'd3)) begin
                        nph_next = 3'd4; sgl = 1'b1; sgl_ev = EV_NUM_BYTE; sgl_db = c;
                    end else if ((c == "+" || c == "-") && nph_reg == 3'd4) begin
                        nph_next = 3'd5; sgl = 1'b1; sgl_ev = EV_NUM_BYTE; sgl_db = c;
                    end else if (nph_reg == 3'd1 || nph_reg == 3'd3 || nph_reg == 3'd6) begin
                        // number ends; the byte is read again after the value
                        numend = 1'b1; nph_next = '0; ph_next = PH_AFTER;
                        af_go = 1'b1;
                    end else begin
                        flt = 1'b1;
                    end
                end
                PH_LITERAL: begin
                    if (lkind == 2'd3 || lpos >= llen || c != lit_char(lkind, lpos)) begin
                        flt = 1'b1;
                    end else if (lpos + 3'd1 == llen) begin
                        sgl = 1'b1;
                        sgl_ev = (lkind == 2'd0) ? EV_TRUE :
                                 (lkind == 2'd1) ? EV_FALSE : EV_NULL;
                        lit_next = '0; ph_next = PH_AFTER;
                    end else begin
                        lit_next = {lkind, lpos + 3'd1};
                    end
                end
                default: flt = 1'b1;
            endcase

            // completed \u escape
            if (fh_go) begin
                if (fh_cp >= 16'hd800 && fh_cp <= 16'hdbff) begin
                    pend_next = fh_cp; pendv_next = 1'b1; ph_next = PH_PEND;
                end else begin
                    utf_go = 1'b1; utf_cp = {5'd0, fh_cp}; ph_next = PH_STRING;
                end
            end

            // byte inside a string
            if (str_go) begin
                if (c == "\"") begin
                    sgl = 1'b1; sgl_ev = key_reg ? EV_KEY_END : EV_STR_END;
                    ph_next = key_reg ? PH_COLON : PH_AFTER;
                    key_next = 1'b0;
                end else if (c == "\\") begin
                    ph_next = PH_ESC;
                end else begin
                    sgl = 1'b1; sgl_ev = sev; sgl_db = c;
                end
            end

            // byte after a backslash
            if (esc_go) begin
                ph_next = PH_STRING;
                sgl_ev = sev;
                sgl = 1'b1;
                case (c)
                    "\"":    sgl_db = 8'h22;
                    "\\":    sgl_db = 8'h5c;
                    "/":     sgl_db = 8'h2f;
                    "b":     sgl_db = 8'h08;
                    "f":     sgl_db = 8'h0c;
                    "n":     sgl_db = 8'h0a;
                    "r":     sgl_db = 8'h0d;
                    "t":     sgl_db = 8'h09;
                    "u": begin
                        sgl = 1'b0; acc_next = '0; hcnt_next = '0; ph_next = PH_HEX;
                    end
                    default: begin
                        sgl = 1'b0; flt = 1'b1;
                    end
                endcase
            end

            // first byte of a value
            if (sv_go) begin
                if (cnt_reg > CNT_W'(MAX_DEPTH)) begin
                    flt = 1'b1;
                end else if (c == "{" || c == "[") begin
                    stk_next = {stk_reg[STACK_W-2:0], c == "{"};
                    cnt_next = cnt_reg + 1'b1;
                    sgl = 1'b1;
                    sgl_ev = (c == "{") ? EV_OBJ_OPEN : EV_ARR_OPEN;
                    ph_next = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
                end else if (c == "\"") begin
                    key_next = 1'b0; ph_next = PH_STRING;
                end else if (c == "t" || c == "f" || c == "n") begin
                    lit_next = {(c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2, 3'd1};
                    ph_next = PH_LITERAL;
                end else if (c == "-" || (c >= "0" && c <= "9")) begin
                    sgl = 1'b1; sgl_ev = EV_NUM_BYTE; sgl_db = c;
                    nph_next = (c == "-") ? 3'd0 : 3'd1;
                    ph_next = PH_NUMBER;
                end else begin
                    flt = 1'b1;
                end
            end

            // separator or close after a value
            if (af_go && !ws) begin
                if (cnt_reg == '0 || cnt_reg > CNT_W'(STACK_W)) begin
                    flt = 1'b1;
                end else if (c == ",") begin
                    ph_next = stk_reg[0] ? PH_KEY : PH_VALUE;
                end else if ((c == "}" && stk_reg[0]) || (c == "]" && !stk_reg[0])) begin
                    cnt_next = cnt_reg - 1'b1;
                    stk_next = stk_reg >> 1;
                    sgl = 1'b1;
                    sgl_ev = stk_reg[0] ? EV_OBJ_CLOSE : EV_ARR_CLOSE;
                    ph_next = PH_AFTER;
                end else begin
                    flt = 1'b1;
                end
            end

            if (flt) fail_next = 1'b1;
        end
    end

    assign enc_p = utf8_enc({5'd0, pend_reg});
    assign enc_u = utf8_enc(utf_cp);

    // result list in output order
    always_comb begin
        rn = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            rev[i] = EV_NONE;
            rdb[i] = 8'h00;
        end
        if (flt) begin
            rev[0] = EV_ERROR;
            rn = RES_W'(1);
        end else begin
            if (numend) begin
                rev[rn] = EV_NUM_END; rn = rn + 1'b1;
            end
            if (flush) begin
                for (int i = 0; i < 3; i++) begin
                    rev[rn] = sev; rdb[rn] = enc_p.b[i]; rn = rn + 1'b1;
                end
            end
            if (utf_go) begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < enc_u.len) begin
                        rev[rn] = sev; rdb[rn] = enc_u.b[i]; rn = rn + 1'b1;
                    end
                end
            end
            if (sgl) begin
                rev[rn] = sgl_ev; rdb[rn] = sgl_db; rn = rn + 1'b1;
            end
        end
    end

    // handshake: take a request when the queue is empty or its last result is being taken
    assign m_valid        = qi_reg < qn_reg;
    assign m_last_of_item = (qi_reg + 1'b1) == qn_reg;
    assign s_ready        = (qi_reg == qn_reg) || (m_last_of_item && m_ready);
    assign m_event_res    = qev_reg[qi_reg[RES_W-1:0] < RES_W'(MAX_RES) ? qi_reg : '0];
    assign m_data_byte    = qdb_reg[qi_reg[RES_W-1:0] < RES_W'(MAX_RES) ? qi_reg : '0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_TOP; stk_reg <= '0; cnt_reg <= '0; key_reg <= 1'b0;
            acc_reg <= '0; hcnt_reg <= '0; pend_reg <= '0; pendv_reg <= 1'b0;
            lit_reg <= '0; nph_reg <= '0; fail_reg <= 1'b0;
            qn_reg <= '0; qi_reg <= '0;
        end else begin
            if (take) begin
                ph_reg <= ph_next; stk_reg <= stk_next; cnt_reg <= cnt_next;
                key_reg <= key_next; acc_reg <= acc_next; hcnt_reg <= hcnt_next;
                pend_reg <= pend_next; pendv_reg <= pendv_next; lit_reg <= lit_next;
                nph_reg <= nph_next; fail_reg <= fail_next;
                qn_reg <= rn; qi_reg <= '0;
            end else if (m_valid && m_ready) begin
                qi_reg <= qi_reg + 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < MAX_RES; i++) begin
                qev_reg[i] <= rev[i];
                qdb_reg[i] <= rdb[i];
            end
        end
    end

    // nesting never exceeds the stack
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_W))
        else $error("open count beyond stack");

    // queue index stays within the loaded results
    a_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        qi_reg <= qn_reg && qn_reg <= RES_W'(MAX_RES))
        else $error("result queue out of range");

    // end mark returns the parser to reset
    a_endmark: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_action |=> ph_reg == PH_TOP && cnt_reg == '0 && !fail_reg)
        else $error("end mark did not clear state");

    // a request never gives an empty list when it faults
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        take && flt |=> qn_reg == RES_W'(1) && qev_reg[0] == EV_ERROR)
        else $error("fault did not give a single error");

endmodule
`default_nettype wire

// File: verif/json_stream_tokenizer_check.sv
`default_nettype none
module json_stream_tokenizer_check
    import jst_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_text_byte,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [3:0] m_event_res,
    input  wire logic [7:0] m_data_byte,
    input  wire logic       m_last_of_item,
    output int              mismatches,
    output int              events_waiting,
    output int              events_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] data;
        logic       last;
    } token_t;

    token_t token_q[$];

    // tokenizer state mirror
    phase_t               ph;
    logic [STACK_W-1:0]   is_obj_stack;
    int                   depth;
    logic                 key_mode;
    logic [15:0]          hex_acc;
    int                   hex_n;
    logic [15:0]          high_half;
    logic [1:0]           lit_kind;
    int                   lit_pos;
    int                   num_ph;
    logic                 faulted;

    // tokens caused by the request in hand
    token_t step_tok[MAX_RES];
    int     step_n;

    function automatic void clear_state();
        ph = PH_TOP;
        is_obj_stack = '0;
        depth = 0;
        key_mode = 1'b0;
        hex_acc = '0;
        hex_n = 0;
        high_half = '0;
        lit_kind = 2'd0;
        lit_pos = 0;
        num_ph = 0;
        faulted = 1'b0;
    endfunction

    function automatic void put_tok(logic [3:0] ev, logic [7:0] data);
        if (step_n < MAX_RES) begin
            step_tok[step_n] = '{ev: ev, data: data, last: 1'b0};
            step_n++;
        end
    endfunction

    function automatic void fault();
        faulted = 1'b1;
        step_n = 0;
        put_tok(EV_ERROR, 8'h00);
    endfunction

    function automatic logic blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
    endfunction

    function automatic int hexdig(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - 8'h30;
        if (c >= "a" && c <= "f") return c - 8'h61 + 10;
        if (c >= "A" && c <= "F") return c - 8'h41 + 10;
        return -1;
    endfunction

    function automatic void text_out(logic [7:0] b);
        put_tok(key_mode ? EV_KEY_BYTE : EV_STR_BYTE, b);
    endfunction

    // code point as utf-8
    function automatic void code_out(int cp);
        if (cp <= 'h7f) begin
            text_out(cp[7:0]);
        end else if (cp <= 'h7ff) begin
            text_out(8'hc0 | cp[10:6]);
            text_out(8'h80 | cp[5:0]);
        end else if (cp <= 'hffff) begin
            text_out(8'he0 | cp[15:12]);
            text_out(8'h80 | cp[11:6]);
            text_out(8'h80 | cp[5:0]);
        end else begin
            text_out(8'hf0 | cp[20:18]);
            text_out(8'h80 | cp[17:12]);
            text_out(8'h80 | cp[11:6]);
            text_out(8'h80 | cp[5:0]);
        end
    endfunction

    function automatic void code_done(logic [15:0] cp);
        if (cp >= 16'hd800 && cp <= 16'hdbff) begin
            high_half = cp;
            ph = PH_PEND;
        end else begin
            code_out(cp);
            ph = PH_STRING;
        end
    endfunction

    function automatic void in_string(logic [7:0] c);
        if (c == "\"") begin
            put_tok(key_mode ? EV_KEY_END : EV_STR_END, 8'h00);
            ph = key_mode ? PH_COLON : PH_AFTER;
            key_mode = 1'b0;
        end else if (c == "\\") begin
            ph = PH_ESC;
        end else begin
            text_out(c);
        end
    endfunction

    function automatic void in_escape(logic [7:0] c);
        logic [7:0] b;
        case (c)
            "\"", "\\", "/": b = c;
            "b": b = 8'h08;
            "f": b = 8'h0c;
            "n": b = 8'h0a;
            "r": b = 8'h0d;
            "t": b = 8'h09;
            "u": begin
                hex_acc = '0;
                hex_n = 0;
                ph = PH_HEX;
                return;
            end
            default: begin
                fault();
                return;
            end
        endcase
        text_out(b);
        ph = PH_STRING;
    endfunction

    function automatic void open_value(logic [7:0] c);
        if (depth > MAX_DEPTH) begin
            fault();
        end else if (c == "{" || c == "[") begin
            is_obj_stack[depth] = (c == "{");
            depth++;
            put_tok(c == "{" ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00);
            ph = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
        end else if (c == "\"") begin
            key_mode = 1'b0;
            ph = PH_STRING;
        end else if (c == "t" || c == "f" || c == "n") begin
            lit_kind = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
            lit_pos = 1;
            ph = PH_LITERAL;
        end else if (c == "-" || (c >= "0" && c <= "9")) begin
            put_tok(EV_NUM_BYTE, c);
            num_ph = (c == "-") ? 0 : 1;
            ph = PH_NUMBER;
        end else begin
            fault();
        end
    endfunction

    function automatic void close_one(logic obj);
        depth--;
        put_tok(obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'h00);
        ph = PH_AFTER;
    endfunction

    function automatic void after_value(logic [7:0] c);
        logic top;
        if (blank(c)) return;
        if (depth == 0 || depth > MAX_DEPTH + 1) begin
            fault();
            return;
        end
        top = is_obj_stack[depth-1];
        if (c == ",") ph = top ? PH_KEY : PH_VALUE;
        else if (c == "}" && top) close_one(1'b1);
        else if (c == "]" && !top) close_one(1'b0);
        else fault();
    endfunction

    function automatic void take_byte(logic [7:0] c);
        int d;
        int cp;
        logic [7:0] want;
        int len;
        case (ph)
            PH_TOP, PH_VALUE: if (!blank(c)) open_value(c);
            PH_ARR_FIRST: begin
                if (!blank(c)) begin
                    if (c == "]") close_one(1'b0);
                    else open_value(c);
                end
            end
            PH_OBJ_FIRST, PH_KEY: begin
                if (!blank(c)) begin
                    if (c == "}" && ph == PH_OBJ_FIRST) close_one(1'b1);
                    else if (c == "\"") begin
                        key_mode = 1'b1;
                        ph = PH_STRING;
                    end else fault();
                end
            end
            PH_COLON: begin
                if (!blank(c)) begin
                    if (c == ":") ph = PH_VALUE;
                    else fault();
                end
            end
            PH_AFTER: after_value(c);
            PH_STRING: in_string(c);
            PH_ESC: in_escape(c);
            PH_HEX, PH_PEND_HEX: begin
                d = hexdig(c);
                if (d < 0) begin
                    fault();
                end else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    hex_n++;
                    if (hex_n == 4) begin
                        hex_n = 0;
                        if (ph == PH_HEX) begin
                            code_done(hex_acc);
                        end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                            cp = 'h10000 + ((int'(high_half) - 'hd800) << 10)
                                 + (int'(hex_acc) - 'hdc00);
                            code_out(cp);
                            high_half = '0;
                            ph = PH_STRING;
                        end else begin
                            code_out(high_half);
                            high_half = '0;
                            code_done(hex_acc);
                        end
                    end
                end
            end
            PH_PEND: begin
                if (c == "\\") begin
                    ph = PH_PEND_BS;
                end else begin
                    code_out(high_half);
                    high_half = '0;
                    ph = PH_STRING;
                    in_string(c);
                end
            end
            PH_PEND_BS: begin
                if (c == "u") begin
                    hex_acc = '0;
                    hex_n = 0;
                    ph = PH_PEND_HEX;
                end else begin
                    code_out(high_half);
                    high_half = '0;
                    in_escape(c);
                end
            end
            PH_NUMBER: begin
                if (c >= "0" && c <= "9") begin
                    if (num_ph == 0) num_ph = 1;
                    else if (num_ph == 2) num_ph = 3;
                    else if (num_ph == 4 || num_ph == 5) num_ph = 6;
                    put_tok(EV_NUM_BYTE, c);
                end else if (c == "." && num_ph == 1) begin
                    num_ph = 2;
                    put_tok(EV_NUM_BYTE, c);
                end else if ((c == "e" || c == "E") && (num_ph == 1 || num_ph == 3)) begin
                    num_ph = 4;
                    put_tok(EV_NUM_BYTE, c);
                end else if ((c == "+" || c == "-") && num_ph == 4) begin
                    num_ph = 5;
                    put_tok(EV_NUM_BYTE, c);
                end else if (num_ph == 1 || num_ph == 3 || num_ph == 6) begin
                    // the terminator is read again after the number
                    put_tok(EV_NUM_END, 8'h00);
                    num_ph = 0;
                    ph = PH_AFTER;
                    after_value(c);
                end else begin
                    fault();
                end
            end
            PH_LITERAL: begin
                len = (lit_kind == 2'd1) ? 5 : 4;
                want = lit_char(lit_kind, lit_pos[2:0]);
                if (lit_pos >= len || c != want) begin
                    fault();
                end else begin
                    lit_pos++;
                    if (lit_pos == len) begin
                        put_tok(lit_kind == 2'd0 ? EV_TRUE :
                                lit_kind == 2'd1 ? EV_FALSE : EV_NULL, 8'h00);
                        lit_pos = 0;
                        ph = PH_AFTER;
                    end
                end
            end
            default: fault();
        endcase
    endfunction

    // expected tokens for one request
    function automatic void predict_tokens(logic act, logic [7:0] c);
        step_n = 0;
        if (act) begin
            if (faulted) begin
                put_tok(EV_ERROR, 8'h00);
            end else if (depth == 0 && ph == PH_NUMBER &&
                         (num_ph == 1 || num_ph == 3 || num_ph == 6)) begin
                put_tok(EV_NUM_END, 8'h00);
                put_tok(EV_DOC_OK, 8'h00);
            end else if (depth == 0 && ph == PH_AFTER) begin
                put_tok(EV_DOC_OK, 8'h00);
            end else begin
                put_tok(EV_ERROR, 8'h00);
            end
            clear_state();
        end else if (!faulted) begin
            take_byte(c);
        end
        if (step_n > 0) step_tok[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) token_q.push_back(step_tok[i]);
    endfunction

    task automatic report(string what, token_t want);
        $display("%0t: %s: got ev %0d data %02h last %0d, expected ev %0d data %02h last %0d",
                 $realtime, what, m_event_res, m_data_byte, m_last_of_item,
                 want.ev, want.data, want.last);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        events_seen = 0;
        clear_state();
    end

    assign events_waiting = token_q.size();

    // predict on each accepted request, compare each accepted result
    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            clear_state();
            token_q.delete();
        end else begin
            if (s_valid && s_ready) predict_tokens(s_action, s_text_byte);
            if (m_valid && m_ready) begin
                events_seen++;
                if (token_q.size() == 0) begin
                    report("unexpected result", '0);
                end else begin
                    want = token_q.pop_front();
                    if (m_event_res != want.ev || m_data_byte != want.data ||
                        m_last_of_item != want.last)
                        report("result mismatch", want);
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: verif/json_stream_tokenizer_test.sv
`default_nettype none
module json_stream_tokenizer_test;
    import jst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    typedef logic [7:0] text_t[$];

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_action;
    logic [7:0] s_text_byte;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_event_res;
    logic [7:0] m_data_byte;
    logic       m_last_of_item;

    int  mismatches;
    int  events_waiting;
    int  events_seen;
    int  requests_sent;
    int  docs_sent;
    int  quiet_cycles;
    bit  calm;

    json_stream_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_text_byte(s_text_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_res(m_event_res),
        .m_data_byte(m_data_byte), .m_last_of_item(m_last_of_item)
    );

    json_stream_tokenizer_check check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_text_byte(s_text_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_res(m_event_res),
        .m_data_byte(m_data_byte), .m_last_of_item(m_last_of_item),
        .mismatches(mismatches), .events_waiting(events_waiting),
        .events_seen(events_seen)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(99) >= 27);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(logic act, logic [7:0] c);
        if (!calm) begin
            while ($urandom_range(99) < 27) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_text_byte <= c;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic send_doc(text_t doc);
        foreach (doc[i]) send(1'b0, doc[i]);
        send(1'b1, 8'($urandom));
        docs_sent++;
    endtask

    function automatic void add_str(ref text_t d, input string s);
        for (int i = 0; i < s.len(); i++) d.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_ch(logic [3:0] v);
        if (v < 10) return 8'h30 + v;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 10;
    endfunction

    function automatic void add_uesc(ref text_t d, input logic [15:0] v);
        add_str(d, "\\u");
        for (int i = 3; i >= 0; i--) d.push_back(hex_ch(v[i*4 +: 4]));
    endfunction

    function automatic void add_ws(ref text_t d);
        logic [7:0] sp[4] = '{8'h20, 8'h09, 8'h0a, 8'h0d};
        while ($urandom_range(3) == 0) d.push_back(sp[$urandom_range(3)]);
    endfunction

    // string body and closing quote, opening quote already placed
    function automatic void add_string(ref text_t d);
        string esc = "\"\\/bfnrt";
        logic [7:0] c;
        int n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: d.push_back(8'($urandom_range(32, 126)) == "\"" ? "a" :
                                     8'($urandom_range(32, 126)));
                3: begin
                    c = 8'($urandom);
                    if (c == "\"" || c == "\\") c = 8'h00;
                    d.push_back(c);
                end
                4: begin
                    d.push_back("\\");
                    d.push_back(esc[$urandom_range(7)]);
                end
                5: add_uesc(d, 16'($urandom));
                6: begin
                    add_uesc(d, 16'($urandom_range('hd800, 'hdbff)));
                    add_uesc(d, 16'($urandom_range('hdc00, 'hdfff)));
                end
                7: add_uesc(d, 16'($urandom_range('hd800, 'hdfff)));
                default: d.push_back("z");
            endcase
        end
        // a raw byte after a lone backslash could break well-formedness
        for (int i = 0; i < d.size(); i++) if (d[i] == "\"" && 0) d[i] = "a";
        d.push_back("\"");
    endfunction

    function automatic void add_number(ref text_t d);
        if ($urandom_range(2) == 0) d.push_back("-");
        repeat ($urandom_range(1, 3)) d.push_back(8'($urandom_range(48, 57)));
        if ($urandom_range(2) == 0) begin
            d.push_back(".");
            repeat ($urandom_range(1, 2)) d.push_back(8'($urandom_range(48, 57)));
        end
        if ($urandom_range(2) == 0) begin
            d.push_back($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0: d.push_back("+");
                1: d.push_back("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) d.push_back(8'($urandom_range(48, 57)));
        end
    endfunction

    function automatic void add_value(ref text_t d, input int lvl);
        int n;
        add_ws(d);
        case ((lvl > 2) ? 2 + $urandom_range(3) : $urandom_range(5))
            0: begin
                d.push_back("[");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i) d.push_back(",");
                    add_value(d, lvl + 1);
                end
                add_ws(d);
                d.push_back("]");
            end
            1: begin
                d.push_back("{");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i) d.push_back(",");
                    add_ws(d);
                    d.push_back("\"");
                    add_string(d);
                    add_ws(d);
                    d.push_back(":");
                    add_value(d, lvl + 1);
                end
                add_ws(d);
                d.push_back("}");
            end
            2: begin
                d.push_back("\"");
                add_string(d);
            end
            3: add_number(d);
            4: add_str(d, "true");
            default: add_str(d, $urandom_range(1) ? "false" : "null");
        endcase
        add_ws(d);
    endfunction

    function automatic text_t from_str(string s);
        text_t d;
        add_str(d, s);
        return d;
    endfunction

    initial begin
        text_t doc;
        int pos;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = 1'b0;
        s_text_byte = 8'h00;
        calm = 1'b0;
        quiet_cycles = 0;
        requests_sent = 0;
        docs_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed documents: grammar corners and escape handling
        send_doc(from_str("{}"));
        send_doc(from_str(" [ ] "));
        send_doc(from_str("007"));
        send_doc(from_str("-0.5E+12"));
        send_doc(from_str("[1e-3,true,false,null]"));
        send_doc(from_str("{\"k\":\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"}"));
        send_doc(from_str("\"\\ud83d\\ude00\\u00e9\\u0041\\uFFFF\""));
        // high surrogate left unpaired, then plain text, an escape, a non-low
        send_doc(from_str("\"\\ud800x\\ud801\\n\\udbff\\u0042\\udc00\""));
        send_doc(from_str("\"\\ud800\\ud800\\udc00\""));
        send_doc(from_str("\"\\q\""));
        send_doc(from_str("[1,]x"));
        send_doc(from_str("tru"));
        send_doc(from_str("1."));
        send_doc(from_str("{\"a\" 1}"));
        doc = {8'h22, 8'h00, 8'hff, 8'h7f, 8'h80, 8'h22};
        send_doc(doc);
        // deepest nesting allowed, then one level beyond it
        doc.delete();
        repeat (MAX_DEPTH + 1) doc.push_back("[");
        repeat (MAX_DEPTH + 1) doc.push_back("]");
        send_doc(doc);
        doc.delete();
        repeat (MAX_DEPTH + 2) doc.push_back("[");
        send_doc(doc);
        send(1'b1, 8'h00);

        // random documents: mostly well formed, some damaged, some noise
        while (requests_sent < 230 + 300) begin
            calm = (docs_sent % 20) >= 14;
            doc.delete();
            case ($urandom_range(9))
                0: repeat ($urandom_range(1, 8)) doc.push_back(8'($urandom));
                1, 2: begin
                    add_value(doc, 0);
                    pos = $urandom_range(doc.size() - 1);
                    if ($urandom_range(1)) doc[pos] = 8'($urandom);
                    else doc = doc[0:pos];
                end
                default: add_value(doc, 0);
            endcase
            send_doc(doc);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        wait (events_waiting == 0);
        repeat (20) @(posedge aclk);
        $display("%0d requests in %0d documents, %0d results checked",
                 requests_sent, docs_sent, events_seen);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
